FILE: rtl/iirlp_pkg.sv
// Package with the constants, register indexes and state type of the fourth-order IIR filter.
package iirlp_pkg;

    localparam int TAPS        = 4;
    localparam int ORDER       = 4;
    localparam int GAIN_BITS   = 20;
    localparam int STATE_BITS  = 40;
    localparam int SAMPLE_BITS = 24;
    localparam int ACC_BITS    = 64;
    localparam int DIGIT_BITS  = 4;
    localparam int DIGITS      = GAIN_BITS / DIGIT_BITS;
    localparam int TAP_W       = $clog2(TAPS + 1);
    localparam int DIG_W       = $clog2(DIGITS);
    localparam int DLY_IDX_W   = $clog2(TAPS);
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 2 * GAIN_BITS;

    localparam logic [CFG_IDX_BITS-1:0] REG_FF_GAIN_0  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FF_GAIN_1  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_FF_GAIN_2  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_FF_GAIN_3  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_FF_GAIN_4  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_FB_GAIN_1  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_FB_GAIN_2  = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_FB_GAIN_34 = 3'd7;

    localparam logic signed [GAIN_BITS-1:0] FF_GAIN_0_RESET = 20'sd65536;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FB,
        ST_WSAT,
        ST_FF,
        ST_YSAT
    } state_t;

endpackage

FILE: rtl/iir_fourth_order_lowpass.sv
// Fourth-order direct form II IIR low-pass filter with a digit-serial multiply-accumulate unit.
//
// Each accepted sample word gives one filtered word. All nine multiply-accumulates share one
// 64-bit by 4-bit digit multiplier that consumes one 4-bit digit of a 20-bit gain per cycle.
// One sample runs the feedback pass over ORDER taps, rounds and saturates the internal value,
// runs the feedforward pass over ORDER+1 taps, rounds and saturates the output and goes idle.
// A finished word waits in the output register, and the next sample is accepted while it
// waits; the block only stalls when a second result is ready before the first is taken.
// The user must write gains through wr_en, wr_index and wr_data only while the block is idle;
// the block itself does not enforce this.
module iir_fourth_order_lowpass (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   wr_en,
    input  logic [iirlp_pkg::CFG_IDX_BITS-1:0]     wr_index,
    input  logic [iirlp_pkg::CFG_DATA_BITS-1:0]    wr_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [iirlp_pkg::SAMPLE_BITS-1:0] sample,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [iirlp_pkg::SAMPLE_BITS-1:0] filtered_sample,
    output logic                                   clipped
);
    import iirlp_pkg::*;

    localparam logic [TAP_W-1:0] LAST_TAP   = TAP_W'(ORDER);
    localparam logic [DIG_W-1:0] LAST_DIGIT = DIG_W'(DIGITS - 1);

    state_t state_reg, state_next;

    logic signed [GAIN_BITS-1:0]  ffg_reg [0:TAPS];
    logic signed [GAIN_BITS-1:0]  fbg_reg [1:TAPS];
    logic signed [STATE_BITS-1:0] delay_reg [0:TAPS-1];

    logic [TAP_W-1:0]             tap_reg;
    logic [DIG_W-1:0]             dig_reg;
    logic signed [ACC_BITS-1:0]   acc_reg, acc_next;
    logic signed [ACC_BITS-1:0]   mcand_reg, mcand_next;
    logic signed [STATE_BITS-1:0] w_reg, w_next;
    logic                         hit_reg;
    logic                         out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg, y_next;
    logic                         out_clip_reg;

    logic                         accept_in, mac_en, w_load, y_load, last_digit, last_tap;
    logic [DLY_IDX_W-1:0]         dly_idx;
    logic [TAP_W-1:0]             tap_m1;
    logic signed [STATE_BITS-1:0] src_val;
    logic [GAIN_BITS-1:0]         gain_val;
    logic [DIGIT_BITS-1:0]        digit;
    logic signed [DIGIT_BITS:0]   digit_s;
    logic signed [ACC_BITS-1:0]   cur_mcand, prod;
    logic signed [ACC_BITS-1:0]   w_round, w_shift, y_round, y_shift;
    logic                         w_over, y_over;

    assign last_digit = (dig_reg == LAST_DIGIT);
    assign last_tap   = (tap_reg == LAST_TAP);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_FB;
            end
            ST_FB:
            begin
                if (last_digit && last_tap)
                    state_next = ST_WSAT;
            end
            ST_WSAT:
            begin
                state_next = ST_FF;
            end
            ST_FF:
            begin
                if (last_digit && last_tap)
                    state_next = ST_YSAT;
            end
            ST_YSAT:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs.
    always_comb
    begin
        in_ready = 1'b0;
        mac_en   = 1'b0;
        w_load   = 1'b0;
        y_load   = 1'b0;
        case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_FB:   mac_en   = 1'b1;
            ST_WSAT: w_load   = 1'b1;
            ST_FF:   mac_en   = 1'b1;
            ST_YSAT: y_load   = !out_valid_reg || out_ready;
            default: in_ready = 1'b0;
        endcase
    end

    assign accept_in = in_valid && in_ready;

    // Operand selection and the digit multiplier.
    assign tap_m1  = tap_reg - TAP_W'(1);
    assign dly_idx = tap_m1[DLY_IDX_W-1:0];

    always_comb
    begin
        if (state_reg == ST_FB)
        begin
            src_val  = delay_reg[dly_idx];
            gain_val = fbg_reg[tap_reg];
        end
        else
        begin
            src_val  = (tap_reg == '0) ? w_reg : delay_reg[dly_idx];
            gain_val = ffg_reg[tap_reg];
        end
        digit     = gain_val[dig_reg*DIGIT_BITS +: DIGIT_BITS];
        digit_s   = {(last_digit ? digit[DIGIT_BITS-1] : 1'b0), digit};
        cur_mcand = (dig_reg == '0) ? ACC_BITS'(src_val) : mcand_reg;
        prod      = cur_mcand * digit_s;
        mcand_next = cur_mcand <<< DIGIT_BITS;
        acc_next  = acc_reg + prod;
    end

    // Rounding and saturation of the internal value and of the output.
    always_comb
    begin
        w_round = acc_reg + (ACC_BITS'(1) <<< 15);
        w_shift = w_round >>> 16;
        w_over  = (w_shift[ACC_BITS-1:STATE_BITS-1] != '0) &&
                  (w_shift[ACC_BITS-1:STATE_BITS-1] != '1);
        if (w_over)
            w_next = w_shift[ACC_BITS-1] ? {1'b1, {(STATE_BITS-1){1'b0}}}
                                         : {1'b0, {(STATE_BITS-1){1'b1}}};
        else
            w_next = w_shift[STATE_BITS-1:0];

        y_round = acc_reg + (ACC_BITS'(1) <<< 23);
        y_shift = y_round >>> 24;
        y_over  = (y_shift[ACC_BITS-1:SAMPLE_BITS-1] != '0) &&
                  (y_shift[ACC_BITS-1:SAMPLE_BITS-1] != '1);
        if (y_over)
            y_next = y_shift[ACC_BITS-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                         : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        else
            y_next = y_shift[SAMPLE_BITS-1:0];
    end

    // Control registers and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tap_reg       <= '0;
            dig_reg       <= '0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            ffg_reg[0] <= FF_GAIN_0_RESET;
            for (int i = 1; i <= TAPS; i++)
                ffg_reg[i] <= '0;
            for (int i = 1; i <= TAPS; i++)
                fbg_reg[i] <= '0;
            for (int i = 0; i < TAPS; i++)
                delay_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (wr_en)
            begin
                case (wr_index)
                    REG_FF_GAIN_0:  ffg_reg[0] <= wr_data[GAIN_BITS-1:0];
                    REG_FF_GAIN_1:  ffg_reg[1] <= wr_data[GAIN_BITS-1:0];
                    REG_FF_GAIN_2:  ffg_reg[2] <= wr_data[GAIN_BITS-1:0];
                    REG_FF_GAIN_3:  ffg_reg[3] <= wr_data[GAIN_BITS-1:0];
                    REG_FF_GAIN_4:  ffg_reg[4] <= wr_data[GAIN_BITS-1:0];
                    REG_FB_GAIN_1:  fbg_reg[1] <= wr_data[GAIN_BITS-1:0];
                    REG_FB_GAIN_2:  fbg_reg[2] <= wr_data[GAIN_BITS-1:0];
                    REG_FB_GAIN_34:
                    begin
                        fbg_reg[3] <= wr_data[GAIN_BITS-1:0];
                        fbg_reg[4] <= wr_data[2*GAIN_BITS-1:GAIN_BITS];
                    end
                    default: ;
                endcase
            end

            if (accept_in)
            begin
                tap_reg <= TAP_W'(1);
                dig_reg <= '0;
                hit_reg <= 1'b0;
            end
            else if (mac_en)
            begin
                if (last_digit)
                begin
                    dig_reg <= '0;
                    tap_reg <= tap_reg + TAP_W'(1);
                end
                else
                begin
                    dig_reg <= dig_reg + DIG_W'(1);
                end
            end
            else if (w_load)
            begin
                tap_reg <= '0;
                dig_reg <= '0;
                hit_reg <= w_over;
            end

            if (y_load)
            begin
                out_valid_reg <= 1'b1;
                for (int i = TAPS - 1; i > 0; i--)
                    delay_reg[i] <= delay_reg[i-1];
                delay_reg[0] <= w_reg;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept_in)
            acc_reg <= ACC_BITS'(sample) <<< 24;
        else if (mac_en)
            acc_reg <= acc_next;
        else if (w_load)
            acc_reg <= '0;

        if (mac_en)
            mcand_reg <= mcand_next;

        if (w_load)
            w_reg <= w_next;

        if (y_load)
        begin
            out_sample_reg <= y_next;
            out_clip_reg   <= hit_reg || y_over;
        end
    end

    assign out_valid       = out_valid_reg;
    assign filtered_sample = out_sample_reg;
    assign clipped         = out_clip_reg;

    a_accept_starts_fb: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in |=> (state_reg == ST_FB) && (tap_reg == TAP_W'(1)) && (dig_reg == '0))
        else $error("accepted word did not start the feedback pass");

    a_mac_counters: assert property (@(posedge clk) disable iff (!rst_n)
        mac_en |-> (dig_reg <= LAST_DIGIT) && (tap_reg <= LAST_TAP))
        else $error("tap or digit counter out of range");

    a_fb_no_tap_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FB) |-> (tap_reg != '0))
        else $error("feedback pass reached tap zero");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        y_load |=> out_valid_reg && (state_reg == ST_IDLE))
        else $error("finished word was not presented");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the fourth-order direct form II IIR low-pass filter.
module testbench;
    import iirlp_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_ITEMS    = 150;
    localparam int RANDOM_PHASES  = 9;
    localparam int SETTLE_CYCLES  = 60;

    localparam longint W_MAX = (64'sd1 <<< (STATE_BITS - 1)) - 1;
    localparam longint W_MIN = -W_MAX - 1;
    localparam longint Y_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint Y_MIN = -Y_MAX - 1;

    localparam logic signed [GAIN_BITS-1:0] GAIN_MAX = {1'b0, {(GAIN_BITS - 1){1'b1}}};
    localparam logic signed [GAIN_BITS-1:0] GAIN_MIN = {1'b1, {(GAIN_BITS - 1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    typedef enum {
        GAINS_STABLE,
        GAINS_WILD,
        GAINS_EXTREME
    } gain_kind_t;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] value;
        logic                          clip;
    } filt_word_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0]          wr_index = '0;
    logic [CFG_DATA_BITS-1:0]         wr_data = '0;
    logic                             in_valid = 1'b0;
    logic                             in_ready;
    logic signed [SAMPLE_BITS-1:0]    sample = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    logic signed [SAMPLE_BITS-1:0]    filtered_sample;
    logic                             clipped;

    longint     ff_gain [0:TAPS];
    longint     fb_gain [0:TAPS];
    longint     delay_q [0:TAPS-1];
    filt_word_t pending_filtered [$];

    int mismatches = 0;
    int stall_cycles = 0;
    int hold_left = 0;
    bit hold_req = 1'b0;
    bit hold_taken = 1'b0;
    int rx_gap = 0;
    bit tx_lazy = 1'b1;
    bit rx_lazy = 1'b1;

    iir_fourth_order_lowpass u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .wr_en           (wr_en),
        .wr_index        (wr_index),
        .wr_data         (wr_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .sample          (sample),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .filtered_sample (filtered_sample),
        .clipped         (clipped)
    );

    always #2 clk = ~clk;

    function automatic filt_word_t filter_step(input logic signed [SAMPLE_BITS-1:0] x);
        longint     acc;
        longint     w;
        longint     y;
        logic       hit;
        filt_word_t r;
        hit = 1'b0;
        acc = longint'(x) <<< 24;
        for (int k = 1; k <= ORDER; k++)
        begin
            acc += fb_gain[k] * delay_q[k-1];
        end
        w = (acc + 64'sd32768) >>> 16;
        if (w > W_MAX)
        begin
            w = W_MAX;
            hit = 1'b1;
        end
        else if (w < W_MIN)
        begin
            w = W_MIN;
            hit = 1'b1;
        end
        acc = ff_gain[0] * w;
        for (int k = 1; k <= ORDER; k++)
        begin
            acc += ff_gain[k] * delay_q[k-1];
        end
        y = (acc + 64'sd8388608) >>> 24;
        if (y > Y_MAX)
        begin
            y = Y_MAX;
            hit = 1'b1;
        end
        else if (y < Y_MIN)
        begin
            y = Y_MIN;
            hit = 1'b1;
        end
        for (int k = TAPS - 1; k > 0; k--)
        begin
            delay_q[k] = delay_q[k-1];
        end
        delay_q[0] = w;
        r.value = y[SAMPLE_BITS-1:0];
        r.clip = hit;
        return r;
    endfunction

    function automatic logic [GAIN_BITS-1:0] gain_pick(input gain_kind_t kind, input int span);
        logic [31:0] r;
        int          v;
        r = $urandom;
        v = int'($urandom_range(0, 2 * span)) - span;
        case (kind)
            GAINS_STABLE:  return v[GAIN_BITS-1:0];
            GAINS_WILD:    return r[GAIN_BITS-1:0];
            default:       return r[0] ? GAIN_MAX : GAIN_MIN;
        endcase
    endfunction

    function automatic logic [GAIN_BITS-1:0] junk_bits();
        logic [31:0] r;
        r = $urandom;
        return r[GAIN_BITS-1:0];
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        logic [31:0] r;
        int          v;
        r = $urandom;
        v = int'($urandom_range(0, 4000)) - 2000;
        case ($urandom_range(0, 7))
            0:
            begin
                case (r[1:0])
                    2'd0:    return SAMPLE_MAX;
                    2'd1:    return SAMPLE_MIN;
                    2'd2:    return '0;
                    default: return '1;
                endcase
            end
            1, 2:    return v[SAMPLE_BITS-1:0];
            default: return r[SAMPLE_BITS-1:0];
        endcase
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= data;
        case (idx)
            REG_FF_GAIN_0, REG_FF_GAIN_1, REG_FF_GAIN_2, REG_FF_GAIN_3, REG_FF_GAIN_4:
                ff_gain[idx] = longint'($signed(data[GAIN_BITS-1:0]));
            REG_FB_GAIN_1:
                fb_gain[1] = longint'($signed(data[GAIN_BITS-1:0]));
            REG_FB_GAIN_2:
                fb_gain[2] = longint'($signed(data[GAIN_BITS-1:0]));
            REG_FB_GAIN_34:
            begin
                fb_gain[3] = longint'($signed(data[GAIN_BITS-1:0]));
                fb_gain[4] = longint'($signed(data[2*GAIN_BITS-1:GAIN_BITS]));
            end
            default: ;
        endcase
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic load_gains(input gain_kind_t kind);
        cfg_write(REG_FF_GAIN_0, {junk_bits(), gain_pick(kind, 40000)});
        cfg_write(REG_FF_GAIN_1, {junk_bits(), gain_pick(kind, 40000)});
        cfg_write(REG_FF_GAIN_2, {junk_bits(), gain_pick(kind, 40000)});
        cfg_write(REG_FF_GAIN_3, {junk_bits(), gain_pick(kind, 40000)});
        cfg_write(REG_FF_GAIN_4, {junk_bits(), gain_pick(kind, 40000)});
        cfg_write(REG_FB_GAIN_1, {junk_bits(), gain_pick(kind, 12000)});
        cfg_write(REG_FB_GAIN_2, {junk_bits(), gain_pick(kind, 12000)});
        cfg_write(REG_FB_GAIN_34, {gain_pick(kind, 12000), gain_pick(kind, 12000)});
    endtask

    task automatic load_uniform(input logic [GAIN_BITS-1:0] g);
        cfg_write(REG_FF_GAIN_0, {junk_bits(), g});
        cfg_write(REG_FF_GAIN_1, {junk_bits(), g});
        cfg_write(REG_FF_GAIN_2, {junk_bits(), g});
        cfg_write(REG_FF_GAIN_3, {junk_bits(), g});
        cfg_write(REG_FF_GAIN_4, {junk_bits(), g});
        cfg_write(REG_FB_GAIN_1, {junk_bits(), g});
        cfg_write(REG_FB_GAIN_2, {junk_bits(), g});
        cfg_write(REG_FB_GAIN_34, {g, g});
    endtask

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s);
        int gap;
        gap = tx_lazy ? int'($urandom_range(0, 4)) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample <= s;
        do @(posedge clk); while (!in_ready);
        pending_filtered.push_back(filter_step(s));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_filtered.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic check_word();
        filt_word_t want;
        if (pending_filtered.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected word: filtered_sample %0d clipped %0b",
                         filtered_sample, clipped);
        end
        else
        begin
            want = pending_filtered.pop_front();
            if (filtered_sample !== want.value || clipped !== want.clip)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %0d clipped %0b, got %0d clipped %0b",
                             want.value, want.clip, filtered_sample, clipped);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                check_word();
                rx_gap = rx_lazy ? int'($urandom_range(0, 4)) : 0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap = rx_gap - 1;
            end
            out_ready <= (rx_gap == 0) && (hold_left == 0);
        end
    end

    always @(posedge clk)
    begin
        if (hold_req && !hold_taken)
        begin
            hold_left  <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // With the reset gains the filter passes every sample through unchanged.
    task automatic test_reset_defaults();
        send_sample('0);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(24'sd1);
        send_sample(-24'sd1);
        send_sample(24'sd12345);
        drain_results();
    endtask

    // Full-scale gains drive the internal value and the output into saturation.
    task automatic test_extremes();
        load_uniform(GAIN_MAX);
        repeat (6) send_sample(SAMPLE_MAX);
        repeat (4) send_sample(SAMPLE_MIN);
        drain_results();
        load_uniform(GAIN_MIN);
        repeat (3)
        begin
            send_sample(SAMPLE_MIN);
            send_sample(SAMPLE_MAX);
        end
        drain_results();
    endtask

    task automatic test_backpressure();
        tx_lazy = 1'b0;
        load_gains(GAINS_STABLE);
        hold_req = 1'b1;
        repeat (40) send_sample(rand_sample());
        drain_results();
        tx_lazy = 1'b1;
        repeat (20) send_sample(rand_sample());
        drain_results();
    endtask

    task automatic test_random_phases();
        gain_kind_t kind;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            kind = gain_kind_t'(ph % 3);
            load_gains(kind);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % 40 == 0)
                begin
                    tx_lazy = $urandom_range(0, 3) != 0;
                    rx_lazy = $urandom_range(0, 3) != 0;
                end
                send_sample(rand_sample());
            end
            drain_results();
        end
    endtask

    initial
    begin
        foreach (ff_gain[k])
        begin
            ff_gain[k] = 0;
            fb_gain[k] = 0;
        end
        foreach (delay_q[k])
            delay_q[k] = 0;
        ff_gain[0] = longint'(FF_GAIN_0_RESET);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_extremes();
        test_backpressure();
        test_random_phases();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_filtered.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
